### sv/lad_pkg.sv
// shared types and codes for the linear array deque
package lad_pkg;

	localparam int VALUE_W = 32;

	// request kinds carried on the input tuser
	localparam logic [1:0] REQ_PUSH_BACK  = 2'd0;
	localparam logic [1:0] REQ_PUSH_FRONT = 2'd1;
	localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
	localparam logic [1:0] REQ_POP_BACK   = 2'd3;

	// result status codes carried on the output tuser
	localparam logic [1:0] ST_OK            = 2'd0;
	localparam logic [1:0] ST_OVERFLOW      = 2'd1;
	localparam logic [1:0] ST_FRONT_BLOCKED = 2'd2;
	localparam logic [1:0] ST_UNDERFLOW     = 2'd3;

	localparam logic signed [VALUE_W-1:0] UNDERFLOW_VALUE = -32'sd999;

	localparam int CAP_W = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// decoupling queue between classifier and executor
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic                      is_pop;
		logic                      at_front;
		logic signed [VALUE_W-1:0] value;
	} op_t;

endpackage

### sv/lad_front.sv
// request classifier and short op queue in front of the executor
module lad_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [1:0]                       s_tuser,
	input  logic [lad_pkg::VALUE_W-1:0]      s_tdata,
	output logic                             op_valid,
	input  logic                             op_ready,
	output lad_pkg::op_t                     op
);

	lad_pkg::op_t                  op_in;
	lad_pkg::op_t                  queue_q [lad_pkg::QUEUE_DEPTH];
	logic [lad_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [lad_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [lad_pkg::QCNT_W-1:0]    count_q;
	logic                          fire_in;
	logic                          fire_out;

	always_comb begin
		op_in.value = s_tdata;
		unique case (s_tuser)
			lad_pkg::REQ_PUSH_BACK: begin
				op_in.is_pop   = 1'b0;
				op_in.at_front = 1'b0;
			end
			lad_pkg::REQ_PUSH_FRONT: begin
				op_in.is_pop   = 1'b0;
				op_in.at_front = 1'b1;
			end
			lad_pkg::REQ_POP_FRONT: begin
				op_in.is_pop   = 1'b1;
				op_in.at_front = 1'b1;
			end
			default: begin
				op_in.is_pop   = 1'b1;
				op_in.at_front = 1'b0;
			end
		endcase
	end

	assign s_tready = (count_q != lad_pkg::QCNT_W'(lad_pkg::QUEUE_DEPTH));
	assign op_valid = (count_q != '0);
	assign op       = queue_q[rd_ptr_q];
	assign fire_in  = s_tvalid & s_tready;
	assign fire_out = op_valid & op_ready;

	always_ff @(posedge clk) begin
		if (fire_in) begin
			queue_q[wr_ptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (fire_in) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (fire_out) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (fire_in && !fire_out) begin
				count_q <= count_q + 1'b1;
			end else if (!fire_in && fire_out) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/lad_back.sv
// deque executor: indices, slot memory and result register
module lad_back #(
	parameter int MAX_SLOTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lad_pkg::CAP_W-1:0]     cfg_wdata,
	input  logic                          op_valid,
	output logic                          op_ready,
	input  lad_pkg::op_t                  op,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lad_pkg::VALUE_W-1:0]   m_tdata,
	output logic [1:0]                    m_tuser
);

	localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW = (IW + 1 > lad_pkg::CAP_W) ? IW + 1 : lad_pkg::CAP_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic                              state_q;
	logic [IW-1:0]                     front_q;
	logic [IW-1:0]                     rear_q;
	logic                              empty_q;
	logic [lad_pkg::CAP_W-1:0]         capacity_q;
	logic                              out_valid_q;
	logic signed [lad_pkg::VALUE_W-1:0] pop_value_q;
	logic [1:0]                        status_q;
	logic signed [lad_pkg::VALUE_W-1:0] rd_data_q;
	logic signed [lad_pkg::VALUE_W-1:0] slots_q [MAX_SLOTS];

	logic [CW-1:0]                     cap_ext;
	logic [CW-1:0]                     live_cap;
	logic                              at_limit;
	logic                              launch;
	logic [IW-1:0]                     front_d;
	logic [IW-1:0]                     rear_d;
	logic                              empty_d;
	logic                              wr_en;
	logic [IW-1:0]                     wr_addr;
	logic                              rd_en;
	logic [IW-1:0]                     rd_addr;
	logic [1:0]                        status_d;
	logic signed [lad_pkg::VALUE_W-1:0] value_d;

	// live capacity clamps zero to one and large values to the array size
	assign cap_ext  = CW'(capacity_q);
	assign live_cap = (capacity_q == '0) ? CW'(1) :
	                  (cap_ext > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : cap_ext;
	assign at_limit = (CW'(rear_q) >= live_cap - CW'(1));

	assign op_ready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign launch   = op_valid && op_ready;

	always_comb begin
		front_d  = front_q;
		rear_d   = rear_q;
		empty_d  = empty_q;
		wr_en    = 1'b0;
		wr_addr  = '0;
		rd_en    = 1'b0;
		rd_addr  = front_q;
		status_d = lad_pkg::ST_OK;
		value_d  = '0;
		if (op.is_pop) begin
			if (empty_q) begin
				status_d = lad_pkg::ST_UNDERFLOW;
				value_d  = lad_pkg::UNDERFLOW_VALUE;
			end else if (front_q == rear_q) begin
				// last element: back to the empty layout
				rd_en   = 1'b1;
				rd_addr = front_q;
				front_d = '0;
				rear_d  = '0;
				empty_d = 1'b1;
			end else if (op.at_front) begin
				rd_en   = 1'b1;
				rd_addr = front_q;
				front_d = front_q + IW'(1);
			end else begin
				rd_en   = 1'b1;
				rd_addr = rear_q;
				rear_d  = rear_q - IW'(1);
			end
		end else if (op.at_front) begin
			if (!empty_q && front_q != '0) begin
				front_d = front_q - IW'(1);
				wr_en   = 1'b1;
				wr_addr = front_q - IW'(1);
			end else begin
				status_d = lad_pkg::ST_FRONT_BLOCKED;
			end
		end else begin
			if (empty_q) begin
				front_d = '0;
				rear_d  = '0;
				empty_d = 1'b0;
				wr_en   = 1'b1;
				wr_addr = '0;
			end else if (at_limit) begin
				status_d = lad_pkg::ST_OVERFLOW;
			end else begin
				rear_d  = rear_q + IW'(1);
				wr_en   = 1'b1;
				wr_addr = rear_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (launch && wr_en) begin
			slots_q[wr_addr] <= op.value;
		end
		if (launch && rd_en) begin
			rd_data_q <= slots_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			status_q    <= status_d;
			pop_value_q <= value_d;
		end else if (state_q == ST_READ) begin
			pop_value_q <= rd_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			front_q     <= '0;
			rear_q      <= '0;
			empty_q     <= 1'b1;
			capacity_q  <= lad_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (launch) begin
						front_q <= front_d;
						rear_q  <= rear_d;
						empty_q <= empty_d;
						if (rd_en) begin
							state_q     <= ST_READ;
							out_valid_q <= 1'b0;
						end else begin
							out_valid_q <= 1'b1;
						end
					end else if (m_tready) begin
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b1;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = pop_value_q;
	assign m_tuser  = status_q;

	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !out_valid_q)
		else $error("result register busy while pop data returns");

	a_pop_goes_read: assert property (@(posedge clk) disable iff (!arst_n)
		(launch && rd_en) |=> (state_q == ST_READ))
		else $error("pop read not followed by data cycle");

	a_empty_layout: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (front_q == '0 && rear_q == '0))
		else $error("empty deque with nonzero indices");

	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		!empty_q |-> (front_q <= rear_q))
		else $error("front index passed rear index");

endmodule

### sv/linear_array_deque.sv
// top level of the linear array deque: classifier front, executor back
//
// channel  dir  handshake            payload
// s_*      in   s_tvalid/s_tready    tuser: req_type, tdata: push_value
// m_*      out  m_tvalid/m_tready    tdata: pop_value, tuser: status
// cfg_*    in   cfg_we               cfg_wdata: capacity
//
// a push or underflow pop ends in the idle state, a slot pop passes the read
// state: its registered slot read lands in the result register next cycle
// a two-entry op queue lets the input side keep taking beats while the
// executor or the output side stalls; the result register frees as it drains
// reset clears indices, empties the deque and sets capacity to 64; the slot
// memory has no reset, only written slots are ever read
module linear_array_deque #(
	parameter int MAX_SLOTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input beats
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [1:0]                    s_tuser,   // [1:0] req_type
	input  logic [31:0]                   s_tdata,   // [31:0] push_value
	// result beats
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,   // [31:0] pop_value
	output logic [1:0]                    m_tuser,   // [1:0] status
	// capacity register
	input  logic                          cfg_we,
	input  logic [6:0]                    cfg_wdata
);

	// classified ops between front and back
	logic         op_valid;
	logic         op_ready;
	lad_pkg::op_t op;

	// front: decode request kind and buffer it
	lad_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op       (op)
	);

	// back: index updates, slot memory and result register
	lad_back #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
